// ----- sv/scf_pkg.sv -----
`timescale 1ns / 1ps

package scf_pkg;

  // field widths
  localparam int POS_W      = 24;
  localparam int DAMP_W     = 11;
  localparam int OUT_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int SAT_W      = 36;
  localparam int DAMP_SHIFT = 10;
  localparam int DAMP_BIAS  = (1 << DAMP_SHIFT) - 1;

  // defaults for the top-level parameters
  localparam int DEF_CHAIN_LENGTH   = 64;
  localparam int DEF_SPRING_DIVISOR = 8;

  // register reset values
  localparam logic [DAMP_W-1:0] DAMP_FREE_RESET  = DAMP_W'(300);
  localparam logic [DAMP_W-1:0] DAMP_TOUCH_RESET = DAMP_W'(696);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_FREE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_TOUCH = CFG_IDX_W'(1);

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(POS_MAX);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(POS_MIN);

  // one memory entry: position and velocity of one follower
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
  } scf_entry_t;

  // register loads for the axis datapath stages
  typedef struct packed {
    logic ld_read;
    logic ld_mul;
    logic ld_corr;
    logic ld_vel;
    logic ld_damp;
  } scf_ctrl_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SAT_MAX) begin
      r = POS_MAX;
    end else if (v < SAT_MIN) begin
      r = POS_MIN;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/scf_ram.sv -----
`timescale 1ns / 1ps

module scf_ram #(
  parameter int WIDTH = $bits(scf_pkg::scf_entry_t),
  parameter int DEPTH = scf_pkg::DEF_CHAIN_LENGTH - 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/scf_axis.sv -----
`timescale 1ns / 1ps

module scf_axis #(
  parameter int SPRING_DIVISOR = scf_pkg::DEF_SPRING_DIVISOR
) (
  input  logic                                clk,
  input  scf_pkg::scf_ctrl_t                  ctrl,
  input  logic signed [scf_pkg::POS_W-1:0]    pred,
  input  logic signed [scf_pkg::POS_W-1:0]    pos,
  input  logic signed [scf_pkg::POS_W-1:0]    vel,
  input  logic        [scf_pkg::DAMP_W-1:0]   damp,
  output logic signed [scf_pkg::POS_W-1:0]    vel_new,
  output logic signed [scf_pkg::POS_W-1:0]    pos_new,
  output logic                                pull_zero
);

  localparam int PW      = scf_pkg::POS_W;
  localparam int SW      = scf_pkg::SAT_W;
  localparam int DIV_W   = $clog2(SPRING_DIVISOR + 1);
  localparam int RECIP_W = PW + 1;
  localparam int MUL_W   = PW + RECIP_W;
  localparam int BACK_W  = PW + DIV_W + 1;

  // floor(2^PW / d): quotient estimate is low by at most one for |diff| < 2^PW
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << PW) / SPRING_DIVISOR);
  localparam logic [DIV_W-1:0]   DIVISOR = DIV_W'(SPRING_DIVISOR);

  logic signed [PW:0]   diff;
  logic        [PW:0]   mag_full;
  logic        [MUL_W-1:0]  mul_full;
  logic        [BACK_W-1:0] back;
  logic        [BACK_W-1:0] rem;
  logic        [PW-1:0] q_next;
  logic signed [PW:0]   pull;
  logic signed [SW-1:0] vel_sum;
  logic signed [SW-1:0] dprod;
  logic signed [SW-1:0] biased;
  logic signed [SW-1:0] shifted;

  logic        [PW-1:0] mag_r;
  logic                 neg_r;
  logic signed [PW-1:0] pos_r;
  logic signed [PW-1:0] vel_r;
  logic        [PW-1:0] q0_r;
  logic        [PW-1:0] q_r;
  logic signed [PW-1:0] v1_r;
  logic signed [SW-1:0] dprod_r;

  // read: magnitude and sign of the spring stretch
  assign diff     = {pred[PW-1], pred} - {pos[PW-1], pos};
  assign mag_full = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);

  // mul: reciprocal estimate of the quotient
  assign mul_full = MUL_W'(mag_r) * MUL_W'(RECIP);

  // corr: bump the estimate when the remainder is still a full divisor
  assign back   = BACK_W'(q0_r) * BACK_W'(DIVISOR);
  assign rem    = BACK_W'(mag_r) - back;
  assign q_next = (rem >= BACK_W'(DIVISOR)) ? q0_r + PW'(1) : q0_r;

  // vel: signed pull added to the velocity
  assign pull    = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign vel_sum = SW'(vel_r) + SW'(pull);

  // damp: velocity times numerator
  assign dprod = SW'(v1_r) * SW'($signed({1'b0, damp}));

  // move: divide by 1024 toward zero, then step the position
  assign biased  = dprod_r + (dprod_r[SW-1] ? SW'(scf_pkg::DAMP_BIAS) : SW'(0));
  assign shifted = biased >>> scf_pkg::DAMP_SHIFT;
  assign vel_new = scf_pkg::sat_pos(shifted);
  assign pos_new = scf_pkg::sat_pos(SW'(pos_r) + SW'(vel_new));

  always_ff @(posedge clk) begin
    if (ctrl.ld_read) begin
      mag_r <= mag_full[PW-1:0];
      neg_r <= diff[PW];
      pos_r <= pos;
      vel_r <= vel;
    end
    if (ctrl.ld_mul) begin
      q0_r <= mul_full[PW +: PW];
    end
    if (ctrl.ld_corr) begin
      q_r <= q_next;
    end
    if (ctrl.ld_vel) begin
      v1_r      <= scf_pkg::sat_pos(vel_sum);
      pull_zero <= (q_r == '0);
    end
    if (ctrl.ld_damp) begin
      dprod_r <= dprod;
    end
  end

endmodule

// ----- sv/spring_chain_follower_step_top.sv -----
`timescale 1ns / 1ps

// spring chain follower step: each input item is one physics substep of a chain of
// CHAIN_LENGTH-1 followers pulled behind a leader, positions in 1/256 pixel. the
// position and velocity of every follower live in one synchronous memory entry; a
// sequencer visits the followers from the one nearest the leader, and each visit
// reads the entry, runs the spring pull (divide by SPRING_DIVISOR toward zero),
// damping and move through a six-step x/y datapath and writes the entry back. an
// item is first accepted, which also starts the first read; then the followers
// go through the six steps one after another, since each needs the position its
// predecessor just got. with emit set, each follower's result item leaves as its
// entry is written back, and the sequencer holds while the output register is full
// and not being taken. after reset every entry reads as zero through per-entry
// valid bits, so no clearing pass runs; config writes apply to items taken later.

module spring_chain_follower_step_top #(
  parameter int CHAIN_LENGTH   = scf_pkg::DEF_CHAIN_LENGTH,
  parameter int SPRING_DIVISOR = scf_pkg::DEF_SPRING_DIVISOR
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic        [scf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [scf_pkg::DAMP_W-1:0]    cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [scf_pkg::POS_W-1:0]     leader_x,
  input  logic signed [scf_pkg::POS_W-1:0]     leader_y,
  input  logic                                 touched,
  input  logic                                 gather,
  input  logic                                 emit,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [scf_pkg::OUT_IDX_W-1:0] follower_index,
  output logic signed [scf_pkg::POS_W-1:0]     pos_x,
  output logic signed [scf_pkg::POS_W-1:0]     pos_y,
  output logic                                 last
);

  localparam int PW        = scf_pkg::POS_W;
  localparam int OW        = scf_pkg::OUT_IDX_W;
  localparam int FOLLOWERS = CHAIN_LENGTH - 1;
  localparam int ADDR_W    = (FOLLOWERS > 1) ? $clog2(FOLLOWERS) : 1;
  localparam int ENTRY_W   = $bits(scf_pkg::scf_entry_t);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(FOLLOWERS - 1);

  // one-hot sequencer: accept, then six steps per follower
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_CORR = 7'b0001000,
    S_VEL  = 7'b0010000,
    S_DAMP = 7'b0100000,
    S_MOVE = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [scf_pkg::DAMP_W-1:0] damping_free;
  logic [scf_pkg::DAMP_W-1:0] damping_touch;

  // per-item registers
  logic signed [PW-1:0]       leader_x_r;
  logic signed [PW-1:0]       leader_y_r;
  logic [scf_pkg::DAMP_W-1:0] damp_r;
  logic                       gather_r;
  logic                       emit_r;
  logic [ADDR_W-1:0]          idx;
  logic signed [PW-1:0]       pred_x;
  logic signed [PW-1:0]       pred_y;

  // state memory and its valid bits
  logic [FOLLOWERS-1:0]  entry_valid;
  logic                  rvalid;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  scf_pkg::scf_entry_t   rd_entry;
  scf_pkg::scf_entry_t   wr_entry;

  scf_pkg::scf_ctrl_t    ctrl;
  logic signed [PW-1:0]  own_x;
  logic signed [PW-1:0]  own_y;
  logic signed [PW-1:0]  own_vx;
  logic signed [PW-1:0]  own_vy;
  logic signed [PW-1:0]  vx_new;
  logic signed [PW-1:0]  vy_new;
  logic signed [PW-1:0]  pos_mx;
  logic signed [PW-1:0]  pos_my;
  logic                  pz_x;
  logic                  pz_y;
  logic                  snap;
  logic signed [PW-1:0]  new_x;
  logic signed [PW-1:0]  new_y;

  logic                  accept;
  logic                  go;
  logic                  move_go;
  logic                  at_last;
  logic                  out_load;
  logic [ADDR_W:0]       idx_inc;
  logic [ADDR_W+OW:0]    idx_wide;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // the output register must be free, or emptying, before a follower may retire with emit set
  assign go       = !emit_r || !out_valid || out_ready;
  assign move_go  = (state == S_MOVE) && go;
  assign at_last  = (idx == LAST_IDX);
  assign out_load = move_go && emit_r;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_free  <= scf_pkg::DAMP_FREE_RESET;
      damping_touch <= scf_pkg::DAMP_TOUCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scf_pkg::REG_DAMPING_FREE:  damping_free  <= cfg_data;
        scf_pkg::REG_DAMPING_TOUCH: damping_touch <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_READ;
        S_READ: state <= S_MUL;
        S_MUL:  state <= S_CORR;
        S_CORR: state <= S_VEL;
        S_VEL:  state <= S_DAMP;
        S_DAMP: state <= S_MOVE;
        S_MOVE: begin
          if (go) begin
            state <= at_last ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latch the item, walk the follower index, carry the predecessor position
  always_ff @(posedge clk) begin
    if (accept) begin
      leader_x_r <= leader_x;
      leader_y_r <= leader_y;
      damp_r     <= touched ? damping_touch : damping_free;
      gather_r   <= gather;
      emit_r     <= emit;
      idx        <= '0;
      pred_x     <= leader_x;
      pred_y     <= leader_y;
    end else if (move_go) begin
      idx    <= idx + ADDR_W'(1);
      pred_x <= new_x;
      pred_y <= new_y;
    end
  end

  // reads run one follower ahead of the write, so read and write addresses differ
  assign ram_we    = move_go;
  assign ram_re    = accept || (move_go && !at_last);
  assign ram_raddr = accept ? '0 : idx + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rvalid <= entry_valid[ram_raddr];
    end
  end

  scf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FOLLOWERS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = scf_pkg::scf_entry_t'(ram_rdata);

  // never-written entries read as zero; gather replaces the position by the leader
  assign own_x  = gather_r ? leader_x_r : (rvalid ? rd_entry.x : '0);
  assign own_y  = gather_r ? leader_y_r : (rvalid ? rd_entry.y : '0);
  assign own_vx = rvalid ? rd_entry.vx : '0;
  assign own_vy = rvalid ? rd_entry.vy : '0;

  always_comb begin
    ctrl.ld_read = (state == S_READ);
    ctrl.ld_mul  = (state == S_MUL);
    ctrl.ld_corr = (state == S_CORR);
    ctrl.ld_vel  = (state == S_VEL);
    ctrl.ld_damp = (state == S_DAMP);
  end

  scf_axis #(
    .SPRING_DIVISOR (SPRING_DIVISOR)
  ) u_axis_x (
    .clk       (clk),
    .ctrl      (ctrl),
    .pred      (pred_x),
    .pos       (own_x),
    .vel       (own_vx),
    .damp      (damp_r),
    .vel_new   (vx_new),
    .pos_new   (pos_mx),
    .pull_zero (pz_x)
  );

  scf_axis #(
    .SPRING_DIVISOR (SPRING_DIVISOR)
  ) u_axis_y (
    .clk       (clk),
    .ctrl      (ctrl),
    .pred      (pred_y),
    .pos       (own_y),
    .vel       (own_vy),
    .damp      (damp_r),
    .vel_new   (vy_new),
    .pos_new   (pos_my),
    .pull_zero (pz_y)
  );

  // nearly at rest: an axis with no pull lands on the predecessor
  assign snap  = ((vx_new == PW'(0)) || (vx_new == PW'(1))) &&
                 ((vy_new == PW'(0)) || (vy_new == PW'(1)));
  assign new_x = (snap && pz_x) ? pred_x : pos_mx;
  assign new_y = (snap && pz_y) ? pred_y : pos_my;

  always_comb begin
    wr_entry.x  = new_x;
    wr_entry.y  = new_y;
    wr_entry.vx = vx_new;
    wr_entry.vy = vy_new;
  end

  // follower number, 1 nearest the leader, kept to the field width
  assign idx_inc  = {1'b0, idx} + (ADDR_W+1)'(1);
  assign idx_wide = (ADDR_W+OW+1)'(idx_inc);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      follower_index <= idx_wide[OW-1:0];
      pos_x          <= new_x;
      pos_y          <= new_y;
      last           <= at_last;
    end
  end

`ifndef SYNTH
  // the write-back and the look-ahead read never touch the same entry
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (idx != ram_raddr))
    else $error("state memory read and write at the same entry");

  // a result is only loaded when the previous one is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  // retiring the final follower returns the block to accepting items
  a_end_of_item: assert property (@(posedge clk) disable iff (rst)
    (move_go && at_last) |=> in_ready)
    else $error("sequencer did not return to idle after the final follower");
`endif

endmodule

// ----- verif/tb_spring_chain_follower_step_top.sv -----
`timescale 1ns / 1ps

module tb_spring_chain_follower_step_top;
  import scf_pkg::*;

  // chain geometry at the default parameters
  localparam int     FOLLOWERS   = DEF_CHAIN_LENGTH - 1;
  localparam longint SPRING_DIV  = DEF_SPRING_DIVISOR;
  localparam longint DAMP_ONE    = longint'(1) << DAMP_SHIFT;
  // time for one item to walk the whole chain, plus margin
  localparam int     SETTLE      = 6 * FOLLOWERS + 1 + 64;
  localparam int     IDLE_PCT    = 16;
  localparam int     HOLD_AT     = 60;
  localparam int     HOLD_CYCLES = 1500;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  // one substep request
  typedef struct packed {
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
    logic                    touched;
    logic                    gather;
    logic                    emit;
  } step_item_t;

  // one follower position as the block reports it
  typedef struct packed {
    logic [OUT_IDX_W-1:0]    index;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    last;
  } follower_pos_t;

  // outcome of moving one axis of one follower
  typedef struct {
    longint pos;
    longint vel;
    bit     no_pull;
  } axis_move_t;

  logic                    clk;
  logic                    rst        = 1'b1;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [DAMP_W-1:0]       cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic signed [POS_W-1:0] leader_x   = '0;
  logic signed [POS_W-1:0] leader_y   = '0;
  logic                    touched    = 1'b0;
  logic                    gather     = 1'b0;
  logic                    emit       = 1'b0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [OUT_IDX_W-1:0]    follower_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    last;

  spring_chain_follower_step_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .leader_x       (leader_x),
    .leader_y       (leader_y),
    .touched        (touched),
    .gather         (gather),
    .emit           (emit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .follower_index (follower_index),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .last           (last)
  );

  // pending substeps, expected follower positions
  step_item_t    step_q[$];
  follower_pos_t pos_expect_q[$];

  // predicted chain state and register copies
  logic signed [POS_W-1:0] chain_x [FOLLOWERS];
  logic signed [POS_W-1:0] chain_y [FOLLOWERS];
  logic signed [POS_W-1:0] vel_x   [FOLLOWERS];
  logic signed [POS_W-1:0] vel_y   [FOLLOWERS];
  logic [DAMP_W-1:0]       damp_free_cfg  = DAMP_FREE_RESET;
  logic [DAMP_W-1:0]       damp_touch_cfg = DAMP_TOUCH_RESET;

  step_item_t drv_item;
  int         steps_sent  = 0;
  int         steps_taken = 0;
  int         errors      = 0;
  int         hold_left   = 0;
  bit         held_once   = 1'b0;
  bit         calm        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // saturate to the signed 24-bit range
  function automatic longint clamp24(input longint v);
    longint r;
    r = v;
    if (v > longint'(POS_MAX)) r = longint'(POS_MAX);
    if (v < longint'(POS_MIN)) r = longint'(POS_MIN);
    return r;
  endfunction

  // spring pull, damping and move for one axis
  function automatic axis_move_t move_axis(input longint pred, input longint pos,
                                           input longint vel, input longint damp);
    axis_move_t m;
    longint     pull;
    longint     v;
    pull = (pred - pos) / SPRING_DIV;   // truncates toward zero
    v = clamp24(vel + pull);
    v = clamp24((v * damp) / DAMP_ONE);
    m.vel = v;
    m.pos = clamp24(pos + v);
    m.no_pull = (pull == 0);
    return m;
  endfunction

  // advance the predicted chain by one substep, queue the positions if emitted
  task automatic predict_step(input step_item_t it);
    longint        prev_x;
    longint        prev_y;
    longint        damp;
    axis_move_t    mx;
    axis_move_t    my;
    follower_pos_t r;
    int            i;
    damp = it.touched ? longint'(damp_touch_cfg) : longint'(damp_free_cfg);
    prev_x = it.lx;
    prev_y = it.ly;
    if (it.gather) begin
      for (i = 0; i < FOLLOWERS; i++) begin
        chain_x[i] = it.lx;
        chain_y[i] = it.ly;
      end
    end
    for (i = 0; i < FOLLOWERS; i++) begin
      mx = move_axis(prev_x, chain_x[i], vel_x[i], damp);
      my = move_axis(prev_y, chain_y[i], vel_y[i], damp);
      // nearly at rest: an axis with no pull lands on its predecessor
      if (mx.vel >= 0 && mx.vel <= 1 && my.vel >= 0 && my.vel <= 1) begin
        if (mx.no_pull) mx.pos = prev_x;
        if (my.no_pull) my.pos = prev_y;
      end
      chain_x[i] = POS_W'(mx.pos);
      chain_y[i] = POS_W'(my.pos);
      vel_x[i]   = POS_W'(mx.vel);
      vel_y[i]   = POS_W'(my.vel);
      prev_x = mx.pos;
      prev_y = my.pos;
    end
    if (it.emit) begin
      for (i = 0; i < FOLLOWERS; i++) begin
        r.index = OUT_IDX_W'(i + 1);
        r.x     = chain_x[i];
        r.y     = chain_y[i];
        r.last  = (i == FOLLOWERS - 1);
        pos_expect_q.push_back(r);
      end
    end
  endtask

  function automatic void check_field(input string what, input int follower,
                                      input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch at follower %0d: expected %0d, actual %0d",
               $time, what, follower, want, got);
      errors++;
    end
  endfunction

  // driver: offers queued substeps, idles at random between items
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_step(drv_item);
        steps_taken++;
      end
      if (!in_valid || in_ready) begin
        if (step_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          drv_item = step_q.pop_front();
          in_valid <= 1'b1;
          leader_x <= drv_item.lx;
          leader_y <= drv_item.ly;
          touched  <= drv_item.touched;
          gather   <= drv_item.gather;
          emit     <= drv_item.emit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every result item, stalls at random and once for a long stretch
  always @(posedge clk) begin
    follower_pos_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pos_expect_q.size() == 0) begin
          $display("%0t: unexpected result item: expected none, actual index %0d x %0d y %0d",
                   $time, follower_index, pos_x, pos_y);
          errors++;
        end else begin
          e = pos_expect_q.pop_front();
          check_field("follower_index", e.index, e.index, follower_index);
          check_field("pos_x", e.index, longint'(e.x), longint'(pos_x));
          check_field("pos_y", e.index, longint'(e.y), longint'(pos_y));
          check_field("last", e.index, e.last, last);
        end
      end
      // long hold-off so the block backs up into its input; it starts while a
      // result is waiting and more items are queued, so the stall really happens
      if (!held_once && steps_taken >= HOLD_AT && out_valid && step_q.size() != 0) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic add_step(input logic signed [POS_W-1:0] lx, input logic signed [POS_W-1:0] ly,
                          input logic t, input logic g, input logic e);
    step_item_t it;
    it.lx = lx;
    it.ly = ly;
    it.touched = t;
    it.gather = g;
    it.emit = e;
    step_q.push_back(it);
    steps_sent++;
  endtask

  function automatic int clip_pos(input int v);
    int r;
    r = v;
    if (v > int'(POS_MAX)) r = int'(POS_MAX);
    if (v < int'(POS_MIN)) r = int'(POS_MIN);
    return r;
  endfunction

  function automatic int any_pos();
    return int'($signed(POS_W'($urandom)));
  endfunction

  // random substeps: mostly leader walks and settling holds, some noise
  task automatic add_random_steps(input int n);
    int   left;
    int   len;
    int   kind;
    int   cx;
    int   cy;
    int   k;
    bit   settle;
    logic tch;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        // noise: any value of every field
        add_step(POS_W'($urandom), POS_W'($urandom), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
        left--;
      end else begin
        settle = (kind >= 85);
        len = settle ? $urandom_range(20, 40) : $urandom_range(3, 14);
        tch = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < 80) begin
          cx = int'($urandom_range(0, 65535)) - 32768;
          cy = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          cx = any_pos();
          cy = any_pos();
        end
        for (k = 0; k < len && left > 0; k++) begin
          if (!settle && $urandom_range(0, 99) >= 40) begin
            cx = clip_pos(cx + int'($urandom_range(0, 8190)) - 4095);
            cy = clip_pos(cy + int'($urandom_range(0, 8190)) - 4095);
          end
          if ($urandom_range(0, 99) < 10) tch = ~tch;
          add_step(POS_W'(cx), POS_W'(cy), tch,
                   (k == 0) && ($urandom_range(0, 99) < 35),
                   settle ? (k >= len - 3) : ($urandom_range(0, 99) < 40));
          left--;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DAMP_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DAMPING_FREE) damp_free_cfg = val;
    else if (idx == REG_DAMPING_TOUCH) damp_touch_cfg = val;
  endtask

  // wait until every queued item is taken and every position has come out,
  // then let the last silent substep finish its walk
  task automatic drain_and_settle();
    while (steps_taken != steps_sent || pos_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int i;
    for (i = 0; i < FOLLOWERS; i++) begin
      chain_x[i] = '0;
      chain_y[i] = '0;
      vel_x[i]   = '0;
      vel_y[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset damping: extremes, gather, silent steps, rest and snap
    add_step('0, '0, 1'b0, 1'b1, 1'b1);
    add_step(POS_MAX, POS_MAX, 1'b0, 1'b0, 1'b1);
    add_step(POS_MIN, POS_MIN, 1'b1, 1'b0, 1'b1);
    add_step(POS_MAX, POS_MIN, 1'b0, 1'b1, 1'b1);
    add_step(POS_MIN, POS_MAX, 1'b1, 1'b0, 1'b1);
    add_step(POS_MIN, POS_MAX, 1'b0, 1'b1, 1'b0);
    add_step(-24'sd1, -24'sd1, 1'b1, 1'b0, 1'b0);
    add_step(24'sd5, 24'sd7, 1'b0, 1'b1, 1'b1);
    for (i = 0; i < 8; i++) add_step(24'sd5, 24'sd7, 1'b0, 1'b0, 1'b0);
    add_step(24'sd5, 24'sd7, 1'b0, 1'b0, 1'b1);
    add_step(24'sd12, -24'sd9, 1'b1, 1'b0, 1'b0);
    add_step(24'sd12, -24'sd9, 1'b1, 1'b0, 1'b0);
    add_step(24'sd12, -24'sd9, 1'b1, 1'b0, 1'b1);
    drain_and_settle();

    // full-scale damping; the long receiver hold-off normally lands here
    write_reg(REG_DAMPING_FREE, DAMP_W'(1024));
    write_reg(REG_DAMPING_TOUCH, DAMP_W'(1024));
    add_random_steps(50);
    drain_and_settle();

    // velocity zeroed when free, growth past one when touched: saturation
    write_reg(REG_DAMPING_FREE, '0);
    write_reg(REG_DAMPING_TOUCH, '1);
    add_step(POS_MAX, POS_MAX, 1'b1, 1'b1, 1'b1);
    add_step(POS_MIN, POS_MIN, 1'b1, 1'b0, 1'b1);
    add_step(POS_MAX, POS_MIN, 1'b1, 1'b0, 1'b1);
    add_step(POS_MIN, POS_MAX, 1'b0, 1'b0, 1'b1);
    add_random_steps(42);
    drain_and_settle();

    write_reg(REG_DAMPING_FREE, '1);
    write_reg(REG_DAMPING_TOUCH, '0);
    add_random_steps(45);
    drain_and_settle();

    // undecoded indexes must leave the registers alone; no idling in this phase
    write_reg(REG_UNUSED_2, DAMP_W'($urandom));
    write_reg(REG_UNUSED_3, DAMP_W'($urandom));
    calm = 1'b1;
    add_random_steps(50);
    drain_and_settle();
    calm = 1'b0;

    write_reg(REG_DAMPING_FREE, DAMP_W'(1));
    write_reg(REG_DAMPING_TOUCH, DAMP_W'(1023));
    add_random_steps(50);
    drain_and_settle();

    write_reg(REG_DAMPING_FREE, DAMP_W'($urandom_range(0, 1024)));
    write_reg(REG_DAMPING_TOUCH, DAMP_W'($urandom_range(0, 2047)));
    add_random_steps(50);
    drain_and_settle();

    write_reg(REG_DAMPING_FREE, DAMP_FREE_RESET);
    write_reg(REG_DAMPING_TOUCH, DAMP_TOUCH_RESET);
    add_random_steps(50);
    drain_and_settle();

    if (errors == 0 && pos_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall limit, several times the slowest correct run
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/scf_pkg.sv
sv/scf_ram.sv
sv/scf_axis.sv
sv/spring_chain_follower_step_top.sv
verif/tb_spring_chain_follower_step_top.sv
